[rtl/rrp_pkg.sv]
// ============================================================================
// rrp_pkg
// Relocation patcher package: kind codes, field masks and immediate
// scatter functions for RISC-V instruction formats.
// ============================================================================
`default_nettype none

package rrp_pkg;

    localparam int unsigned CMD_W  = 5;
    localparam int unsigned WORD_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_I       = 5'd0,
        CMD_S       = 5'd1,
        CMD_B       = 5'd2,
        CMD_U       = 5'd3,
        CMD_J       = 5'd4,
        CMD_CB      = 5'd5,
        CMD_CJ      = 5'd6,
        CMD_CALL    = 5'd7,
        CMD_RELAX   = 5'd8,
        CMD_ADD8    = 5'd9,
        CMD_ADD16   = 5'd10,
        CMD_ADD32   = 5'd11,
        CMD_ADD64   = 5'd12,
        CMD_SUB8    = 5'd13,
        CMD_SUB16   = 5'd14,
        CMD_SUB32   = 5'd15,
        CMD_SUB64   = 5'd16,
        CMD_SUB6    = 5'd17,
        CMD_SET6    = 5'd18,
        CMD_SET8    = 5'd19,
        CMD_SET16   = 5'd20,
        CMD_SET32   = 5'd21,
        CMD_SET64   = 5'd22
    } cmd_t;

    localparam logic [31:0] MASK_I   = 32'h000F_FFFF;
    localparam logic [31:0] MASK_SB  = 32'h01FF_F07F;
    localparam logic [31:0] MASK_UJ  = 32'h0000_0FFF;
    localparam logic [15:0] MASK_CB  = 16'hE383;
    localparam logic [15:0] MASK_CJ  = 16'hE003;
    localparam logic [31:0] MASK_RD  = 32'h0000_0F80;
    localparam logic [31:0] JAL_OP   = 32'h0000_006F;
    localparam logic [31:0] U_ROUND  = 32'h0000_0800;

    function automatic logic [31:0] imm_i(input logic [31:0] v);
        return {v[11:0], 20'd0};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] v);
        return {v[11:5], 13'd0, v[4:0], 7'd0};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] v);
        return {v[12], v[10:5], 13'd0, v[4:1], v[11], 7'd0};
    endfunction

    function automatic logic [31:0] imm_u(input logic [31:0] v);
        logic [31:0] t;
        t = v + U_ROUND;
        return {t[31:12], 12'd0};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] v);
        return {v[20], v[10:1], v[11], v[19:12], 12'd0};
    endfunction

    function automatic logic [15:0] imm_cb(input logic [31:0] v);
        return {3'd0, v[8], v[4], v[3], 3'd0, v[7], v[6], v[2], v[1], v[5], 2'd0};
    endfunction

    function automatic logic [15:0] imm_cj(input logic [31:0] v);
        return {3'd0, v[11], v[4], v[9], v[8], v[10], v[6], v[7], v[3], v[2], v[1],
                v[5], 2'd0};
    endfunction

endpackage

`default_nettype wire

[rtl/riscv_relocation_patcher_core.sv]
// ============================================================================
// riscv_relocation_patcher_core
// Patches one RISC-V code or data location per transaction: instruction
// immediates, call pairs, relaxed calls and ADD/SUB/SET data relocations.
// ============================================================================
//
//  channel | signals                               | dir
//  --------+---------------------------------------+-----
//  in      | in_valid, in_ready, command,          | in
//          | old_word, value                       |
//  out     | out_valid, out_ready, new_word,       | out
//          | bad_command                           |
//
//  One transaction per cycle sustained while the sink accepts; a transaction
//  passes the input register, then patch logic into the result register. The
//  64-bit add/subtract sets the critical path. Reset clears both valid flags;
//  payload is not reset. A stalled result holds the result register; the input
//  register keeps accepting while it is empty or moving into a free result register.
// ============================================================================
`default_nettype none

module riscv_relocation_patcher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [4:0]  command,
    input  wire logic [63:0] old_word,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      new_word,
    output logic             bad_command
);

    logic        s1_valid_reg;
    logic [4:0]  cmd_reg;
    logic [63:0] old_reg;
    logic [63:0] val_reg;

    logic        out_valid_reg;
    logic [63:0] new_word_reg;
    logic        bad_reg;

    logic [63:0] new_word_next;
    logic        bad_next;
    logic        s1_move;
    logic        in_take;

    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] v32;
    logic [63:0] sum;
    logic [63:0] dif;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= command;
            old_reg <= old_word;
            val_reg <= value;
        end
        if (s1_move)
        begin
            new_word_reg <= new_word_next;
            bad_reg      <= bad_next;
        end
    end

    assign w0  = old_reg[31:0];
    assign w1  = old_reg[63:32];
    assign v32 = val_reg[31:0];
    assign sum = old_reg + val_reg;
    assign dif = old_reg - val_reg;

    always_comb
    begin
        new_word_next = old_reg;
        bad_next      = 1'b0;
        case (cmd_reg)
            rrp_pkg::CMD_I:
                new_word_next[31:0] = (w0 & rrp_pkg::MASK_I) | rrp_pkg::imm_i(v32);
            rrp_pkg::CMD_S:
                new_word_next[31:0] = (w0 & rrp_pkg::MASK_SB) | rrp_pkg::imm_s(v32);
            rrp_pkg::CMD_B:
                new_word_next[31:0] = (w0 & rrp_pkg::MASK_SB) | rrp_pkg::imm_b(v32);
            rrp_pkg::CMD_U:
                new_word_next[31:0] = (w0 & rrp_pkg::MASK_UJ) | rrp_pkg::imm_u(v32);
            rrp_pkg::CMD_J:
                new_word_next[31:0] = (w0 & rrp_pkg::MASK_UJ) | rrp_pkg::imm_j(v32);
            rrp_pkg::CMD_CB:
                new_word_next[15:0] = (w0[15:0] & rrp_pkg::MASK_CB) | rrp_pkg::imm_cb(v32);
            rrp_pkg::CMD_CJ:
                new_word_next[15:0] = (w0[15:0] & rrp_pkg::MASK_CJ) | rrp_pkg::imm_cj(v32);
            rrp_pkg::CMD_CALL:
            begin
                new_word_next[31:0]  = (w0 & rrp_pkg::MASK_UJ) | rrp_pkg::imm_u(v32);
                new_word_next[63:32] = (w1 & rrp_pkg::MASK_I) | rrp_pkg::imm_i(v32);
            end
            rrp_pkg::CMD_RELAX:
                new_word_next[31:0] = (w1 & rrp_pkg::MASK_RD) | rrp_pkg::JAL_OP
                                      | rrp_pkg::imm_j(v32);
            rrp_pkg::CMD_ADD8:  new_word_next[7:0]  = sum[7:0];
            rrp_pkg::CMD_ADD16: new_word_next[15:0] = sum[15:0];
            rrp_pkg::CMD_ADD32: new_word_next[31:0] = sum[31:0];
            rrp_pkg::CMD_ADD64: new_word_next       = sum;
            rrp_pkg::CMD_SUB8:  new_word_next[7:0]  = dif[7:0];
            rrp_pkg::CMD_SUB16: new_word_next[15:0] = dif[15:0];
            rrp_pkg::CMD_SUB32: new_word_next[31:0] = dif[31:0];
            rrp_pkg::CMD_SUB64: new_word_next       = dif;
            rrp_pkg::CMD_SUB6:  new_word_next[5:0]  = dif[5:0];
            rrp_pkg::CMD_SET6:  new_word_next[5:0]  = val_reg[5:0];
            rrp_pkg::CMD_SET8:  new_word_next[7:0]  = val_reg[7:0];
            rrp_pkg::CMD_SET16: new_word_next[15:0] = val_reg[15:0];
            rrp_pkg::CMD_SET32: new_word_next[31:0] = val_reg[31:0];
            rrp_pkg::CMD_SET64: new_word_next       = val_reg;
            default:
            begin
                new_word_next = old_reg;
                bad_next      = 1'b1;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign new_word    = new_word_reg;
    assign bad_command = bad_reg;

    // back-pressure only when both stages hold and the sink stalls
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a full, stalled pipeline");

    // unknown kinds pass the word through with the flag set
    a_bad_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && cmd_reg > rrp_pkg::CMD_SET64) |=>
        (bad_command && new_word == $past(old_reg)))
        else $error("undefined kind not passed through");

    // a held input stage keeps its transaction while the result stage is stalled
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=>
        (s1_valid_reg && $stable(cmd_reg) && $stable(old_reg) && $stable(val_reg)))
        else $error("input stage lost a waiting transaction");

endmodule

`default_nettype wire
